// ----- sv/scpf_pkg.sv -----
package scpf_pkg;

  localparam int unsigned MaxPayload = 64;

  localparam logic [7:0] ADDR_BYTE = 8'hFF;
  localparam logic [7:0] LEN_EXTRA = 8'd2;

  // register indexes, decoded from paddr[2]
  localparam logic REG_SYNC_WORD   = 1'b0;
  localparam logic REG_PACKET_TYPE = 1'b1;

  // byte slots of one framed item, in send order
  localparam logic [3:0] SLOT_SC_HI  = 4'd0;
  localparam logic [3:0] SLOT_SC_LO  = 4'd1;
  localparam logic [3:0] SLOT_ADDR0  = 4'd2;
  localparam logic [3:0] SLOT_ADDR1  = 4'd3;
  localparam logic [3:0] SLOT_ADDR2  = 4'd4;
  localparam logic [3:0] SLOT_ADDR3  = 4'd5;
  localparam logic [3:0] SLOT_TYPE   = 4'd6;
  localparam logic [3:0] SLOT_LEN_HI = 4'd7;
  localparam logic [3:0] SLOT_LEN_LO = 4'd8;
  localparam logic [3:0] SLOT_DATA   = 4'd9;
  localparam logic [3:0] SLOT_CK_HI  = 4'd10;
  localparam logic [3:0] SLOT_CK_LO  = 4'd11;

  // everything the sender needs to put out the bytes of one request
  typedef struct packed {
    logic        hdr;
    logic        cks;
    logic [7:0]  data;
    logic [15:0] sync_word;
    logic [7:0]  ptype;
    logic [15:0] len;
    logic [15:0] sum;
  } job_t;

endpackage

// ----- sv/scpf_framer.sv -----
module scpf_framer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        payload_byte_i,
  input  logic [6:0]        payload_count_i,
  input  logic [15:0]       sync_word_i,
  input  logic [7:0]        packet_type_i,
  output logic              job_load_o,
  output scpf_pkg::job_t    job_o
);
  import scpf_pkg::*;

  logic [6:0]  pos_q, pos_d;
  logic [6:0]  size_q, size_d;
  logic [15:0] sum_q, sum_d;

  logic        first;
  logic        count_ok;
  logic [7:0]  len;
  logic [6:0]  size;
  logic [15:0] base;
  logic [15:0] sum;
  logic [6:0]  pos_nx;
  logic        last;

  always_comb begin
    first    = (pos_q == 7'd0);
    count_ok = (payload_count_i != 7'd0) && (payload_count_i <= 7'(MaxPayload));
    len      = {1'b0, payload_count_i} + LEN_EXTRA;
    size     = first ? payload_count_i : size_q;
    // length high byte is zero for any legal count, so both length bytes sum to len
    base     = first ? (16'(len) + 16'(packet_type_i)) : sum_q;
    sum      = base + 16'(payload_byte_i);
    pos_nx   = pos_q + 7'd1;
    last     = (pos_nx >= size);

    job_load_o = accept_i && (!first || count_ok);

    job_o.hdr       = first;
    job_o.cks       = last;
    job_o.data      = payload_byte_i;
    job_o.sync_word = sync_word_i;
    job_o.ptype     = packet_type_i;
    job_o.len       = 16'(len);
    job_o.sum       = sum;

    pos_d  = pos_q;
    size_d = size_q;
    sum_d  = sum_q;
    if (job_load_o) begin
      if (last) begin
        pos_d  = 7'd0;
        size_d = 7'd0;
        sum_d  = 16'd0;
      end else begin
        pos_d  = pos_nx;
        size_d = size;
        sum_d  = sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 7'd0;
      size_q <= 7'd0;
      sum_q  <= 16'd0;
    end else begin
      pos_q  <= pos_d;
      size_q <= size_d;
      sum_q  <= sum_d;
    end
  end

endmodule

// ----- sv/scpf_sender.sv -----
module scpf_sender (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_load_i,
  input  scpf_pkg::job_t    job_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              run_last_o,
  output logic              packet_end_o
);
  import scpf_pkg::*;

  logic       job_vld_q, job_vld_d;
  job_t       job_q;
  logic [3:0] slot_q, slot_d;
  logic       out_vld_q, out_vld_d;
  logic [7:0] byte_q;
  logic       run_last_q;
  logic       pend_q;

  logic       adv;
  logic [3:0] last_slot;
  logic       job_done;
  logic [7:0] cur_byte;

  always_comb begin
    case (slot_q)
      SLOT_SC_HI:  cur_byte = job_q.sync_word[15:8];
      SLOT_SC_LO:  cur_byte = job_q.sync_word[7:0];
      SLOT_ADDR0:  cur_byte = ADDR_BYTE;
      SLOT_ADDR1:  cur_byte = ADDR_BYTE;
      SLOT_ADDR2:  cur_byte = ADDR_BYTE;
      SLOT_ADDR3:  cur_byte = ADDR_BYTE;
      SLOT_TYPE:   cur_byte = job_q.ptype;
      SLOT_LEN_HI: cur_byte = job_q.len[15:8];
      SLOT_LEN_LO: cur_byte = job_q.len[7:0];
      SLOT_DATA:   cur_byte = job_q.data;
      SLOT_CK_HI:  cur_byte = job_q.sum[15:8];
      SLOT_CK_LO:  cur_byte = job_q.sum[7:0];
      default:     cur_byte = job_q.data;
    endcase
  end

  always_comb begin
    adv        = !out_vld_q || out_ready_i;
    last_slot  = job_q.cks ? SLOT_CK_LO : SLOT_DATA;
    job_done   = job_vld_q && adv && (slot_q == last_slot);
    // take the next request while the final byte of this one moves out
    in_ready_o = !job_vld_q || job_done;

    job_vld_d = job_vld_q;
    slot_d    = slot_q;
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = job_vld_q;
      if (job_vld_q) begin
        slot_d = slot_q + 4'd1;
      end
    end
    if (job_done) begin
      job_vld_d = 1'b0;
    end
    if (job_load_i) begin
      job_vld_d = 1'b1;
      slot_d    = job_i.hdr ? SLOT_SC_HI : SLOT_DATA;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
      slot_q    <= SLOT_SC_HI;
      out_vld_q <= 1'b0;
    end else begin
      job_vld_q <= job_vld_d;
      slot_q    <= slot_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load_i) begin
      job_q <= job_i;
    end
    if (adv && job_vld_q) begin
      byte_q     <= cur_byte;
      run_last_q <= (slot_q == last_slot);
      pend_q     <= job_q.cks && (slot_q == SLOT_CK_LO);
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_byte_o   = byte_q;
  assign run_last_o   = run_last_q;
  assign packet_end_o = pend_q;

endmodule

// ----- sv/sensor_command_packet_framer_core.sv -----
// Channel      | Dir | tdata (low bit up)                         | tlast      | tuser
// -------------+-----+--------------------------------------------+------------+---------
// s_axis       | in  | payload_byte[7:0], payload_count[14:8]     | -          | -
// m_axis       | out | out_byte[7:0]                              | packet_end | run_last
// apb          | cfg | 0x0 sync_word[15:0], 0x4 packet_type[7:0]  | -          | -
//
// Each request puts out one byte per cycle while m_axis is ready: 1 byte mid-packet,
// 10 on the first byte of a packet, 3 on the last, 12 for a one-byte packet; the
// byte sequencer in the sender sets that figure. A request is taken in the cycle the
// previous one's last byte enters the output register, so requests flow back to back.
// A first byte with a count of 0 or above 64 is taken and dropped.
// Reset clears packet state and the output valid flag; no clearing pass.
// A stall on m_axis holds the output byte and, once the sequencer is full, s_axis.
module sensor_command_packet_framer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // payload_byte[7:0], payload_count[14:8], 0
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // out_byte[7:0]
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o,   // run_last[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import scpf_pkg::*;

  logic [15:0] sync_word_q;
  logic [7:0]  packet_type_q;
  logic        cfg_wr;
  logic        accept;
  logic        job_load;
  job_t        job;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q   <= 16'hEF01;
      packet_type_q <= 8'h01;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SYNC_WORD) begin
        sync_word_q <= pwdata[15:0];
      end else begin
        packet_type_q <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_PACKET_TYPE) ? {24'd0, packet_type_q}
                                                : {16'd0, sync_word_q};

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  scpf_framer u_framer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .payload_byte_i  (s_axis_tdata_i[7:0]),
    .payload_count_i (s_axis_tdata_i[14:8]),
    .sync_word_i     (sync_word_q),
    .packet_type_i   (packet_type_q),
    .job_load_o      (job_load),
    .job_o           (job)
  );

  scpf_sender u_sender (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_load_i   (job_load),
    .job_i        (job),
    .in_ready_o   (s_axis_tready_o),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (m_axis_tdata_o),
    .run_last_o   (m_axis_tuser_o),
    .packet_end_o (m_axis_tlast_o)
  );

endmodule

// ----- sv/scpf_checker.sv -----
module scpf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o,
  input logic       m_axis_tuser_o,
  input logic       pready
);

  // a held output byte must not change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)
      && $stable(m_axis_tuser_o))
    else $error("output byte changed under stall");

  // the checksum low byte always closes its request's run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o)
    else $error("packet end without run end");

  // a taken byte that does not end its run is followed by more of the run, never by a gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tuser_o |=> m_axis_tvalid_o)
    else $error("run broken off before its last byte");

  // hold the input while a stalled byte is not the last of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i && !m_axis_tuser_o |-> !s_axis_tready_o)
    else $error("request taken while a run is stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind sensor_command_packet_framer_core scpf_checker u_scpf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .pready          (pready)
);

// ----- tb/sv/scpf_frame_checker.sv -----
module scpf_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [15:0] s_axis_tdata_i,   // payload_byte[7:0], payload_count[14:8], 0
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,   // out_byte[7:0]
  input  logic        m_axis_tlast_i,
  input  logic        m_axis_tuser_i,   // run_last[0]
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic [31:0] prdata_i,
  input  logic        pready_i,
  output int          mismatches_o,
  output int          bytes_pending_o
);
  import scpf_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       packet_end;
  } serial_byte_t;

  serial_byte_t serial_bytes_q[$];

  logic [15:0] sync_word_q;
  logic [7:0]  ptype_q;
  logic [6:0]  byte_pos_q;
  logic [6:0]  pkt_size_q;
  logic [15:0] sum_q;

  logic [31:0]  reg_want;
  serial_byte_t got_byte;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches_o < 40) begin
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    end
    mismatches_o++;
  endtask

  // Build the serial bytes one request causes and queue them in send order.
  task automatic predict_frame_bytes(input logic [7:0] data, input logic [6:0] count);
    logic [7:0]   seq [12];
    logic [15:0]  len;
    int           n;
    logic         closes;
    serial_byte_t sb;
    n = 0;
    closes = 1'b0;
    if (byte_pos_q == 7'd0) begin
      // drop a first byte whose count is out of range
      if (count == 7'd0 || count > 7'(MaxPayload)) return;
      pkt_size_q = count;
      len = {9'd0, count} + {8'd0, LEN_EXTRA};
      seq[0] = sync_word_q[15:8];
      seq[1] = sync_word_q[7:0];
      seq[2] = ADDR_BYTE;
      seq[3] = ADDR_BYTE;
      seq[4] = ADDR_BYTE;
      seq[5] = ADDR_BYTE;
      seq[6] = ptype_q;
      seq[7] = len[15:8];
      seq[8] = len[7:0];
      n = 9;
      sum_q = {8'd0, len[15:8]} + {8'd0, len[7:0]} + {8'd0, ptype_q};
    end
    seq[n] = data;
    n++;
    sum_q = sum_q + {8'd0, data};
    byte_pos_q = byte_pos_q + 7'd1;
    if (byte_pos_q >= pkt_size_q) begin
      seq[n] = sum_q[15:8];
      seq[n + 1] = sum_q[7:0];
      n = n + 2;
      closes = 1'b1;
      byte_pos_q = 7'd0;
      pkt_size_q = 7'd0;
      sum_q = 16'd0;
    end
    for (int i = 0; i < n; i++) begin
      sb.out_byte = seq[i];
      sb.run_last = (i == n - 1);
      sb.packet_end = closes && (i == n - 1);
      serial_bytes_q.push_back(sb);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      serial_bytes_q.delete();
      sync_word_q = 16'hEF01;
      ptype_q = 8'd1;
      byte_pos_q = 7'd0;
      pkt_size_q = 7'd0;
      sum_q = 16'd0;
      mismatches_o = 0;
      bytes_pending_o = 0;
    end else begin
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          if (paddr_i[2] == REG_SYNC_WORD) sync_word_q = pwdata_i[15:0];
          else ptype_q = pwdata_i[7:0];
        end else begin
          reg_want = (paddr_i[2] == REG_SYNC_WORD) ? {16'd0, sync_word_q} : {24'd0, ptype_q};
          if (prdata_i !== reg_want) report_mismatch("register read", prdata_i, reg_want);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_frame_bytes(s_axis_tdata_i[7:0], s_axis_tdata_i[14:8]);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (serial_bytes_q.size() == 0) begin
          report_mismatch("byte with nothing pending", int'(m_axis_tdata_i), 0);
        end else begin
          got_byte = serial_bytes_q.pop_front();
          if (m_axis_tdata_i !== got_byte.out_byte)
            report_mismatch("out_byte", int'(m_axis_tdata_i), int'(got_byte.out_byte));
          if (m_axis_tuser_i !== got_byte.run_last)
            report_mismatch("run_last", int'(m_axis_tuser_i), int'(got_byte.run_last));
          if (m_axis_tlast_i !== got_byte.packet_end)
            report_mismatch("packet_end", int'(m_axis_tlast_i), int'(got_byte.packet_end));
        end
      end
      bytes_pending_o = serial_bytes_q.size();
    end
  end

endmodule

// ----- tb/sv/sensor_command_packet_framer_core_test.sv -----
module sensor_command_packet_framer_core_test;
  import scpf_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 60;

  localparam logic [2:0] ADDR_SYNC_WORD   = {REG_SYNC_WORD, 2'b00};
  localparam logic [2:0] ADDR_PACKET_TYPE = {REG_PACKET_TYPE, 2'b00};

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata;      // payload_byte[7:0], payload_count[14:8], 0
  logic        m_axis_tvalid_o;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata_o;    // out_byte[7:0]
  logic        m_axis_tlast_o;
  logic        m_axis_tuser_o;    // run_last[0]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int bytes_pending;
  int quiet_cycles = 0;
  int tx_calm;
  int rx_calm;

  sensor_command_packet_framer_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  scpf_frame_checker frame_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tlast_i  (m_axis_tlast_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_i        (prdata),
    .pready_i        (pready),
    .mismatches_o    (mismatches),
    .bytes_pending_o (bytes_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Pick a random wait, with occasional stretches of no waiting at all.
  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 12);
  endfunction

  task automatic send_payload(input logic [7:0] data, input logic [6:0] count);
    int gap;
    gap = pick_wait(tx_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, count, data};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Drop valid, drain all pending bytes, then let a dropped request settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (bytes_pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_registers(input logic [15:0] sync_word, input logic [7:0] ptype);
    apb_access(1'b1, ADDR_SYNC_WORD, {16'($urandom_range(0, 65535)), sync_word});
    apb_access(1'b1, ADDR_PACKET_TYPE, {24'($urandom_range(0, 16777215)), ptype});
    apb_access(1'b0, ADDR_SYNC_WORD, 32'd0);
    apb_access(1'b0, ADDR_PACKET_TYPE, 32'd0);
  endtask

  // Mostly short packets, now and then a long one.
  function automatic logic [6:0] pick_size();
    if ($urandom_range(0, 9) == 0) return 7'($urandom_range(9, MaxPayload));
    return 7'($urandom_range(1, 8));
  endfunction

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready)
        || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    m_axis_tready <= 1'b0;
    rx_calm = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      int stall;
      stall = pick_wait(rx_calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  initial begin
    int         items;
    logic [6:0] size;
    tx_calm = 0;
    items = 0;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= 16'd0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= 3'd0;
    pwdata <= 32'd0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset register values, then counts out of range on a first byte
    apb_access(1'b0, ADDR_SYNC_WORD, 32'd0);
    apb_access(1'b0, ADDR_PACKET_TYPE, 32'd0);
    send_payload(8'h5A, 7'd0);
    send_payload(8'hA5, 7'd65);
    send_payload(8'hFF, 7'd127);
    // one-byte packets
    send_payload(8'h00, 7'd1);
    send_payload(8'hFF, 7'd1);
    // counts on later bytes carry no weight
    send_payload(8'hFF, 7'd2);
    send_payload(8'h00, 7'd127);
    // change registers in the middle of a packet
    send_payload(8'h12, 7'd3);
    wait_idle();
    set_registers(16'hFFFF, 8'h00);
    send_payload(8'h34, 7'h55);
    send_payload(8'h56, 7'h2A);
    send_payload(8'h80, 7'd1);
    wait_idle();
    set_registers(16'h0000, 8'hFF);
    send_payload(8'h7F, 7'd2);
    send_payload(8'h01, 7'd64);
    send_payload(8'hC3, 7'd0);
    send_payload(8'hAA, 7'd1);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      set_registers(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      // the first phase opens with a full-size packet
      size = (ph == 0) ? 7'(MaxPayload) : pick_size();
      while (items < (ph + 1) * ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) == 0) begin
          send_payload(8'($urandom_range(0, 255)),
                       $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127)));
        end
        for (int k = 0; k < size; k++) begin
          send_payload(8'($urandom_range(0, 255)),
                       (k == 0) ? size : 7'($urandom_range(0, 127)));
          items++;
        end
        size = pick_size();
      end
    end

    wait_idle();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/scpf_pkg.sv
sv/scpf_framer.sv
sv/scpf_sender.sv
sv/sensor_command_packet_framer_core.sv
sv/scpf_checker.sv
tb/sv/scpf_frame_checker.sv
tb/sv/sensor_command_packet_framer_core_test.sv
